@@ rtl/assert_macros.svh @@
// assertion macros used by the frame driver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on rising clk outside reset
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on rising clk outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lmcfd_pkg.sv @@
// shared types, constants and bar masks of the led chain frame driver
`default_nettype none

package lmcfd_pkg;

  localparam int unsigned DIGITS_PER_DEVICE = 8;
  localparam int unsigned SLOT_W            = 7;
  localparam logic [3:0]  BAR_MAX_LEVEL     = 4'd10;
  localparam logic [7:0]  SEG_TOP_BIT       = 8'h80;
  localparam logic [6:0]  LED_NUM_MAX       = 7'd64;
  localparam logic [2:0]  BAR_FIRST         = 3'd1;
  localparam logic [2:0]  BAR_LAST          = 3'd6;
  localparam logic [2:0]  BAR_SPLIT         = 3'd5;

  typedef enum logic [1:0] {
    OP_SET_LED     = 2'd0,
    OP_SET_LED_NUM = 2'd1,
    OP_SHOW_BAR    = 2'd2,
    OP_RAW_WRITE   = 2'd3
  } op_t;

  // bar masks over the two digit bytes, high byte goes to the lower digit
  function automatic logic [15:0] bar_mask(input logic [2:0] bar);
    logic [15:0] m;
    case (bar)
      3'd1, 3'd5: m = 16'hFFC0;
      3'd2, 3'd6: m = 16'h3FF0;
      3'd3:       m = 16'h0FFC;
      3'd4:       m = 16'h03FF;
      default:    m = 16'h0000;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/led_matrix_chain_frame_driver.sv @@
// frame driver for a daisy chain of led matrix controllers with shadow store
`default_nettype none

// Each accepted item turns into zero, one or two bursts of 16-bit frames, one
// frame per device in the chain, highest device first; out_last marks the
// frame for device 0. The digit shadow lives in one synchronous memory with a
// registered read, kept as zero until written by per-entry valid flops, so no
// clearing pass follows reset. A rejected item is dropped while idle; a set-LED
// reads and modifies its byte and emits a burst only if it flips a bit; a raw
// write goes straight to emit; a show-bar makes two read-modify-write passes on
// the memory port, each with its own burst. The output register moves one
// frame per cycle while out_stall is low. Input is taken only between items; a
// last frame may still sit in the output register when the next item is taken.
module led_matrix_chain_frame_driver
  import lmcfd_pkg::*;
#(
  parameter int unsigned MAX_DEVICES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_device_count,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [2:0]  in_device_index,
  input  wire logic [2:0]  in_digit_index,
  input  wire logic [2:0]  in_segment_index,
  input  wire logic [6:0]  in_led_number,
  input  wire logic        in_led_on,
  input  wire logic [2:0]  in_bar_index,
  input  wire logic [3:0]  in_bar_level,
  input  wire logic [3:0]  in_reg_address,
  input  wire logic [7:0]  in_reg_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_frame_word,
  output logic             out_last
);

  localparam int unsigned DEPTH     = MAX_DEVICES * DIGITS_PER_DEVICE;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CHAIN_CAP = (MAX_DEVICES < 8) ? MAX_DEVICES : 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_EMIT
  } state_t;

  state_t       state_r;
  op_t          op_r;
  logic [3:0]   dev_count_r;
  logic [2:0]   dev_r;
  logic [2:0]   dig_r;
  logic [3:0]   addr_r;
  logic [7:0]   data_r;
  logic [7:0]   seg_bit_r;
  logic         on_r;
  logic [15:0]  mask_r;
  logic [15:0]  pat_r;
  logic         second_r;
  logic [2:0]   k_r;
  logic         out_valid_r;
  logic [15:0]  out_frame_r;
  logic         out_last_r;

  // shadow memory and its written flags
  logic [7:0]        shadow_mem [DEPTH];
  logic [DEPTH-1:0]  written_r;
  logic [7:0]        rd_data_r;
  logic              rd_written_r;

  // effective chain length: zero acts as one, saturate at the cap
  logic [3:0] chain;
  always_comb begin
    if (dev_count_r == 4'd0) begin
      chain = 4'd1;
    end else if (dev_count_r > 4'(CHAIN_CAP)) begin
      chain = 4'(CHAIN_CAP);
    end else begin
      chain = dev_count_r;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r <= 4'd1;
    end else if (cfg_wr_en) begin
      dev_count_r <= cfg_device_count;
    end
  end

  // decode of the incoming beat
  logic        in_accept;
  logic [6:0]  led_z;
  logic [15:0] in_mask;
  logic [15:0] in_pat;
  logic [2:0]  bar_top;
  logic        in_ok;
  logic [2:0]  in_dig;
  logic [2:0]  in_seg;
  logic [3:0]  in_addr;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign led_z     = in_led_number - 7'd1;
  assign in_mask   = bar_mask(in_bar_index);
  assign in_pat    = (in_mask << (BAR_MAX_LEVEL - in_bar_level)) & in_mask;
  assign bar_top   = (in_bar_index < BAR_SPLIT) ? in_bar_index : in_bar_index + 3'd1;

  always_comb begin
    in_ok   = ({1'b0, in_device_index} < chain);
    in_dig  = in_digit_index;
    in_seg  = in_segment_index;
    in_addr = {1'b0, in_digit_index} + 4'd1;
    case (op_t'(in_opcode))
      OP_SET_LED: begin
      end
      OP_SET_LED_NUM: begin
        if (in_led_number == 7'd0 || in_led_number > LED_NUM_MAX) begin
          in_ok = 1'b0;
        end
        in_dig  = led_z[5:3];
        in_seg  = led_z[2:0];
        in_addr = {1'b0, led_z[5:3]} + 4'd1;
      end
      OP_SHOW_BAR: begin
        if (in_bar_index < BAR_FIRST || in_bar_index > BAR_LAST
            || in_bar_level > BAR_MAX_LEVEL) begin
          in_ok = 1'b0;
        end
        in_dig  = bar_top;
        in_addr = {1'b0, bar_top} + 4'd1;
      end
      OP_RAW_WRITE: begin
        in_addr = in_reg_address;
      end
      default: begin
        in_ok = 1'b0;
      end
    endcase
  end

  // memory address of the current digit
  logic [SLOT_W-1:0] slot_full;
  logic [ADDR_W-1:0] mem_addr;
  assign slot_full = {1'b0, dev_r, dig_r};
  assign mem_addr  = slot_full[ADDR_W-1:0];

  // modify step on the byte just read
  logic [7:0] old_byte;
  logic       cur_bit;
  logic       is_bar;
  logic       wr_en;
  logic [7:0] new_byte;

  assign old_byte = rd_written_r ? rd_data_r : 8'h00;
  assign cur_bit  = |(old_byte & seg_bit_r);
  assign is_bar   = (op_r == OP_SHOW_BAR);
  assign wr_en    = (state_r == ST_MODIFY) && (is_bar || (cur_bit != on_r));

  always_comb begin
    if (!is_bar) begin
      new_byte = old_byte ^ seg_bit_r;
    end else if (second_r) begin
      new_byte = (old_byte & ~mask_r[15:8]) | pat_r[15:8];
    end else begin
      new_byte = (old_byte & ~mask_r[7:0]) | pat_r[7:0];
    end
  end

  // shadow memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      shadow_mem[mem_addr] <= new_byte;
    end
    rd_data_r <= shadow_mem[mem_addr];
  end

  // written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[mem_addr] <= 1'b1;
      end
      rd_written_r <= written_r[mem_addr];
    end
  end

  // output register can take a frame
  logic out_load;
  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // sequencer with output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
      k_r         <= 3'd0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_accept && in_ok) begin
            op_r      <= op_t'(in_opcode);
            dev_r     <= in_device_index;
            dig_r     <= in_dig;
            addr_r    <= in_addr;
            data_r    <= in_reg_value;
            seg_bit_r <= SEG_TOP_BIT >> in_seg;
            on_r      <= in_led_on;
            mask_r    <= in_mask;
            pat_r     <= in_pat;
            second_r  <= 1'b0;
            k_r       <= 3'(chain - 4'd1);
            if (op_t'(in_opcode) == OP_RAW_WRITE) begin
              state_r <= ST_EMIT;
            end else begin
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_r <= ST_MODIFY;
        end
        ST_MODIFY: begin
          if (wr_en) begin
            data_r  <= new_byte;
            k_r     <= 3'(chain - 4'd1);
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_frame_r <= (k_r == dev_r) ? {4'd0, addr_r, data_r} : 16'h0000;
            out_last_r  <= (k_r == 3'd0);
            k_r         <= k_r - 3'd1;
            if (k_r == 3'd0) begin
              if (is_bar && !second_r) begin
                second_r <= 1'b1;
                dig_r    <= dig_r - 3'd1;
                addr_r   <= addr_r - 4'd1;
                state_r  <= ST_READ;
              end else begin
                state_r  <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_word = out_frame_r;
  assign out_last       = out_last_r;

  // checks
`include "assert_macros.svh"

  `ASSERT_SAME(a_emit_in_chain, state_r == ST_EMIT, {1'b0, k_r} < chain, "frame index beyond chain")
  `ASSERT_SAME(a_modify_after_read, state_r == ST_MODIFY, $past(state_r) == ST_READ, "modify without read")
  `ASSERT_NEXT(a_noop_frame, out_load && (k_r != dev_r), out_frame_word == 16'h0000, "bad no-op frame")

endmodule

`default_nettype wire

@@ sim/tb_led_matrix_chain_frame_driver.sv @@
// testbench for the led matrix chain frame driver: directed table, random beats, frame checks
`timescale 1ns / 1ps

module tb_led_matrix_chain_frame_driver
  import lmcfd_pkg::*;
();

  localparam int unsigned MAX_DEV        = 8;
  localparam int unsigned SETTLE_CYC     = 40;
  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int unsigned RAND_PER_PHASE = 32;
  // bar spans, bar 1 in the low word
  localparam logic [95:0] BAR_SPANS = {16'h3FF0, 16'hFFC0, 16'h03FF,
                                       16'h0FFC, 16'h3FF0, 16'hFFC0};

  // where the expected frames of a beat come from
  typedef enum logic [1:0] {
    EXP_FROM_MODEL,
    EXP_NOTHING,
    EXP_WORD
  } exp_src_t;

  typedef struct packed {
    logic        set_cfg;
    logic [3:0]  cfg_val;
    op_t         op;
    logic [2:0]  dev;
    logic [2:0]  dig;
    logic [2:0]  seg;
    logic [6:0]  num;
    logic        on;
    logic [2:0]  bar;
    logic [3:0]  lvl;
    logic [3:0]  addr;
    logic [7:0]  val;
    exp_src_t    chk;
    logic [15:0] word;
  } led_cmd_t;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_device_count;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [2:0]  in_device_index;
  logic [2:0]  in_digit_index;
  logic [2:0]  in_segment_index;
  logic [6:0]  in_led_number;
  logic        in_led_on;
  logic [2:0]  in_bar_index;
  logic [3:0]  in_bar_level;
  logic [3:0]  in_reg_address;
  logic [7:0]  in_reg_value;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_frame_word;
  logic        out_last;

  // expectation source travels with the payload
  exp_src_t    row_src;
  logic [15:0] row_word;

  // predictor state
  logic [3:0]  chain_setting = 4'd1;
  logic [7:0]  shadow_digits [0:MAX_DEV*DIGITS_PER_DEVICE-1];
  frame_t      pending_frames [$];
  led_cmd_t    taken_cmd;
  frame_t      want;

  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 14;
  int unsigned recv_stall_pct = 87;
  int unsigned hold_len       = 0;
  led_cmd_t    script [$];

  led_matrix_chain_frame_driver #(
    .MAX_DEVICES(MAX_DEV)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_device_count (cfg_device_count),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_device_index  (in_device_index),
    .in_digit_index   (in_digit_index),
    .in_segment_index (in_segment_index),
    .in_led_number    (in_led_number),
    .in_led_on        (in_led_on),
    .in_bar_index     (in_bar_index),
    .in_bar_level     (in_bar_level),
    .in_reg_address   (in_reg_address),
    .in_reg_value     (in_reg_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_word   (out_frame_word),
    .out_last         (out_last)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // effective chain length: zero acts as one, saturates at the device limit
  function automatic int unsigned active_chain();
    if (chain_setting == 4'd0) return 1;
    if (chain_setting > MAX_DEV) return MAX_DEV;
    return chain_setting;
  endfunction

  // one frame per device, highest first, target gets the word
  function automatic void queue_burst(input logic [2:0] dev, input logic [15:0] word,
                                      input bit keep);
    if (!keep) return;
    for (int k = int'(active_chain()) - 1; k >= 0; k--)
      pending_frames.push_back({(k == int'(dev)) ? word : 16'h0000, k == 0});
  endfunction

  // shadow update and frames of one accepted beat
  function automatic void predict_frames(input led_cmd_t c);
    int unsigned slot, base, top, bot;
    logic [6:0]  led_z;
    logic [2:0]  dig, seg;
    logic [7:0]  mask8, top_addr, bot_addr;
    logic [15:0] span, fill;
    bit          keep;
    keep = (c.chk == EXP_FROM_MODEL);
    if (c.dev >= active_chain()) return;
    case (c.op)
      OP_SET_LED, OP_SET_LED_NUM: begin
        dig = c.dig;
        seg = c.seg;
        if (c.op == OP_SET_LED_NUM) begin
          if (c.num == 7'd0 || c.num > LED_NUM_MAX) return;
          led_z = c.num - 7'd1;
          dig   = led_z[5:3];
          seg   = led_z[2:0];
        end
        slot  = c.dev * DIGITS_PER_DEVICE + dig;
        mask8 = SEG_TOP_BIT >> seg;
        // no frames when the bit already matches
        if (((shadow_digits[slot] & mask8) != 8'h00) == c.on) return;
        shadow_digits[slot] = shadow_digits[slot] ^ mask8;
        queue_burst(c.dev, {({5'd0, dig} + 8'd1), shadow_digits[slot]}, keep);
      end
      OP_SHOW_BAR: begin
        if (c.bar < BAR_FIRST || c.bar > BAR_LAST || c.lvl > BAR_MAX_LEVEL) return;
        if (c.bar < BAR_SPLIT) begin
          top = c.bar;
          bot = c.bar - 1;
        end else begin
          top = c.bar + 1;
          bot = c.bar;
        end
        top_addr = 8'(top + 1);
        bot_addr = 8'(bot + 1);
        base = c.dev * DIGITS_PER_DEVICE;
        span = BAR_SPANS[(int'(c.bar) - 1) * 16 +: 16];
        fill = (span << (BAR_MAX_LEVEL - c.lvl)) & span;
        // low byte to the upper digit first, then high byte to the lower digit
        shadow_digits[base+top] = (shadow_digits[base+top] & ~span[7:0]) | fill[7:0];
        queue_burst(c.dev, {top_addr, shadow_digits[base+top]}, keep);
        shadow_digits[base+bot] = (shadow_digits[base+bot] & ~span[15:8]) | fill[15:8];
        queue_burst(c.dev, {bot_addr, shadow_digits[base+bot]}, keep);
      end
      OP_RAW_WRITE: begin
        queue_burst(c.dev, {4'd0, c.addr, c.val}, keep);
      end
      default: begin
      end
    endcase
  endfunction

  // directed row: p/q are dig/seg, num/-, bar/level or addr/value by opcode
  function automatic led_cmd_t mk_row(input op_t op, input int unsigned dev,
                                      input int unsigned p, input int unsigned q,
                                      input int unsigned on, input exp_src_t chk,
                                      input logic [15:0] word);
    led_cmd_t c;
    c      = '0;
    c.op   = op;
    c.dev  = 3'(dev);
    c.on   = 1'(on);
    c.chk  = chk;
    c.word = word;
    c.dig  = 3'($urandom_range(7));
    c.seg  = 3'($urandom_range(7));
    c.num  = 7'($urandom_range(127));
    c.bar  = 3'($urandom_range(7));
    c.lvl  = 4'($urandom_range(15));
    c.addr = 4'($urandom_range(15));
    c.val  = 8'($urandom_range(255));
    case (op)
      OP_SET_LED:     begin c.dig = 3'(p);  c.seg = 3'(q); end
      OP_SET_LED_NUM: begin c.num = 7'(p);                 end
      OP_SHOW_BAR:    begin c.bar = 3'(p);  c.lvl = 4'(q); end
      OP_RAW_WRITE:   begin c.addr = 4'(p); c.val = 8'(q); end
      default:        begin                                end
    endcase
    return c;
  endfunction

  function automatic led_cmd_t cfg_row(input logic [3:0] v);
    led_cmd_t c;
    c         = '0;
    c.set_cfg = 1'b1;
    c.cfg_val = v;
    return c;
  endfunction

  // random beat: mostly well-formed, the rest raw noise over every bit
  function automatic led_cmd_t rand_cmd();
    led_cmd_t c;
    bit       useful;
    c = mk_row(op_t'($urandom_range(3)), $urandom_range(7), 0, 0,
               $urandom_range(1), EXP_FROM_MODEL, 16'h0000);
    c.dig  = 3'($urandom_range(7));
    c.seg  = 3'($urandom_range(7));
    c.num  = 7'($urandom_range(127));
    c.bar  = 3'($urandom_range(7));
    c.lvl  = 4'($urandom_range(15));
    c.addr = 4'($urandom_range(15));
    c.val  = 8'($urandom_range(255));
    useful = ($urandom_range(99) < 80);
    if (useful) begin
      c.dev = 3'($urandom_range(active_chain() - 1));
      c.num = 7'($urandom_range(64, 1));
      c.bar = 3'($urandom_range(6, 1));
      c.lvl = 4'($urandom_range(10));
    end
    return c;
  endfunction

  // offer one beat, hold it until taken
  task automatic offer_cmd(input led_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= c.op;
    in_device_index  <= c.dev;
    in_digit_index   <= c.dig;
    in_segment_index <= c.seg;
    in_led_number    <= c.num;
    in_led_on        <= c.on;
    in_bar_index     <= c.bar;
    in_bar_level     <= c.lvl;
    in_reg_address   <= c.addr;
    in_reg_value     <= c.val;
    row_src          <= c.chk;
    row_word         <= c.word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // write the chain length once the block has drained
  task automatic write_count(input logic [3:0] v);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_wr_en        <= 1'b1;
    cfg_device_count <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [3:0] count, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned hold);
    led_cmd_t    c;
    int unsigned done;
    write_count(count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_len       = hold;
    done           = 0;
    while (done < RAND_PER_PHASE) begin
      c = rand_cmd();
      offer_cmd(c);
      done++;
    end
  endtask

  // receiver: random stall, or a long hold counted here
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        hold_len = hold_len - 1;
      end else
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // predict on accepted beats, check accepted frames
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) chain_setting = cfg_device_count;
      if (in_valid && !in_stall) begin
        taken_cmd      = '0;
        taken_cmd.op   = op_t'(in_opcode);
        taken_cmd.dev  = in_device_index;
        taken_cmd.dig  = in_digit_index;
        taken_cmd.seg  = in_segment_index;
        taken_cmd.num  = in_led_number;
        taken_cmd.on   = in_led_on;
        taken_cmd.bar  = in_bar_index;
        taken_cmd.lvl  = in_bar_level;
        taken_cmd.addr = in_reg_address;
        taken_cmd.val  = in_reg_value;
        taken_cmd.chk  = row_src;
        taken_cmd.word = row_word;
        predict_frames(taken_cmd);
        if (row_src == EXP_WORD) queue_burst(taken_cmd.dev, row_word, 1'b1);
      end
      if (out_valid && !out_stall) begin
        if (pending_frames.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected frame, expected none, got word %h last %b",
                   $time, out_frame_word, out_last);
        end else begin
          want = pending_frames.pop_front();
          if (want.word !== out_frame_word) begin
            mismatch_cnt++;
            $display("%0t: frame_word expected %h got %h", $time, want.word,
                     out_frame_word);
          end
          if (want.last !== out_last) begin
            mismatch_cnt++;
            $display("%0t: last expected %b got %b", $time, want.last, out_last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // main sequence
  initial begin
    foreach (shadow_digits[i]) shadow_digits[i] = 8'h00;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_device_count <= 4'd0;
    in_valid         <= 1'b0;
    in_opcode        <= OP_SET_LED;
    in_device_index  <= 3'd0;
    in_digit_index   <= 3'd0;
    in_segment_index <= 3'd0;
    in_led_number    <= 7'd0;
    in_led_on        <= 1'b0;
    in_bar_index     <= 3'd0;
    in_bar_level     <= 4'd0;
    in_reg_address   <= 4'd0;
    in_reg_value     <= 8'd0;
    row_src          <= EXP_FROM_MODEL;
    row_word         <= 16'h0000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, chain of one after reset
    script.push_back(mk_row(OP_RAW_WRITE,   0, 15, 255, 0, EXP_WORD,    16'h0FFF));
    script.push_back(mk_row(OP_RAW_WRITE,   1, 3, 8'h5A, 0, EXP_NOTHING, 16'h0000));
    script.push_back(mk_row(OP_SET_LED,     0, 0, 0, 1, EXP_WORD,    16'h0180));
    script.push_back(mk_row(OP_SET_LED,     0, 0, 0, 1, EXP_NOTHING, 16'h0000));
    // zero count acts as one
    script.push_back(cfg_row(4'd0));
    script.push_back(mk_row(OP_RAW_WRITE,   0, 0, 0, 0, EXP_WORD,    16'h0000));
    script.push_back(mk_row(OP_SET_LED_NUM, 1, 5, 0, 1, EXP_NOTHING, 16'h0000));
    // oversize count saturates at eight
    script.push_back(cfg_row(4'd15));
    script.push_back(mk_row(OP_RAW_WRITE,   7, 1, 8'hA5, 0, EXP_WORD, 16'h01A5));
    script.push_back(mk_row(OP_SET_LED,     7, 7, 7, 1, EXP_WORD,    16'h0801));
    script.push_back(mk_row(OP_SET_LED_NUM, 7, 64, 0, 1, EXP_NOTHING, 16'h0000));
    script.push_back(mk_row(OP_SET_LED_NUM, 7, 1, 0, 1, EXP_WORD,    16'h0180));
    script.push_back(mk_row(OP_SET_LED_NUM, 7, 0, 0, 1, EXP_NOTHING, 16'h0000));
    script.push_back(mk_row(OP_SET_LED_NUM, 7, 65, 0, 1, EXP_NOTHING, 16'h0000));
    script.push_back(mk_row(OP_SET_LED_NUM, 7, 127, 0, 1, EXP_NOTHING, 16'h0000));
    script.push_back(mk_row(OP_SET_LED_NUM, 7, 1, 0, 0, EXP_WORD,    16'h0100));
    // bars: full, empty, out of range, each span
    script.push_back(mk_row(OP_SHOW_BAR,    2, 1, 10, 0, EXP_FROM_MODEL, 16'h0000));
    script.push_back(mk_row(OP_SHOW_BAR,    2, 6, 0, 0, EXP_FROM_MODEL, 16'h0000));
    script.push_back(mk_row(OP_SHOW_BAR,    5, 0, 5, 0, EXP_NOTHING, 16'h0000));
    script.push_back(mk_row(OP_SHOW_BAR,    5, 7, 5, 0, EXP_NOTHING, 16'h0000));
    script.push_back(mk_row(OP_SHOW_BAR,    5, 3, 11, 0, EXP_NOTHING, 16'h0000));
    script.push_back(mk_row(OP_SHOW_BAR,    5, 4, 15, 0, EXP_NOTHING, 16'h0000));
    script.push_back(mk_row(OP_SHOW_BAR,    0, 4, 5, 0, EXP_FROM_MODEL, 16'h0000));
    script.push_back(mk_row(OP_SHOW_BAR,    7, 5, 10, 0, EXP_FROM_MODEL, 16'h0000));
    script.push_back(mk_row(OP_SHOW_BAR,    3, 2, 3, 0, EXP_FROM_MODEL, 16'h0000));
    script.push_back(mk_row(OP_SHOW_BAR,    3, 3, 7, 0, EXP_FROM_MODEL, 16'h0000));
    script.push_back(mk_row(OP_SET_LED,     2, 0, 0, 0, EXP_FROM_MODEL, 16'h0000));
    foreach (script[i]) begin
      if (script[i].set_cfg) write_count(script[i].cfg_val);
      else offer_cmd(script[i]);
    end

    // random phases: slow receiver, slow sender, then full rate with a long hold
    run_phase(4'd8, 14, 87, 0);
    run_phase(4'd3, 87, 14, 0);
    run_phase(4'd6, 0, 0, 400);

    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_cnt == 0 && pending_frames.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ led_matrix_chain_frame_driver.f @@
+incdir+rtl
rtl/lmcfd_pkg.sv
rtl/led_matrix_chain_frame_driver.sv
sim/tb_led_matrix_chain_frame_driver.sv
